// ===== src/psc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the panel scan controller.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int MAX_DIGITS_DEF   = 8;
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int MASTER_WORDS     = 6;
  localparam int KEY_ROWS         = 8;
  localparam int DIRTY_W          = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 8;

  localparam logic [7:0] NO_KEY = 8'hff;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WR_DIGIT  = 2'd1,
    OP_WR_MASTER = 2'd2,
    OP_RD_SAMPLE = 2'd3
  } psc_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIGITS   = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_DEBOUNCE = 2'd3
  } psc_cfg_idx_t;

  typedef struct packed {
    psc_op_t    op;
    logic [3:0] index;
    logic [7:0] value;
    logic [7:0] key_sense;
    logic [7:0] adc_sample;
  } psc_item_t;

  typedef struct packed {
    logic [3:0] digits;
    logic [3:0] rows;
    logic [4:0] channels;
    logic [7:0] debounce;
  } psc_cfg_t;

  // slot number and analog channel of the advanced phase
  typedef struct packed {
    logic [2:0] count;
    logic [3:0] chan;
  } psc_phase_t;

  typedef struct packed {
    logic [7:0] seg_row_enable;
    logic [7:0] seg_segments;
    logic [7:0] chan_leds;
    logic [7:0] master_leds;
    logic       master_update;
    logic [7:0] key_row_drive;
    logic [7:0] key_code;
    logic [7:0] key_stable_count;
  } psc_dk_res_t;

  typedef struct packed {
    logic [7:0]         adc_mux_word;
    logic               adc_convert_pulse;
    logic [DIRTY_W-1:0] adc_dirty_mask;
    logic [7:0]         read_value;
  } psc_adc_res_t;

  typedef struct packed {
    psc_dk_res_t  dk;
    psc_adc_res_t adc;
  } psc_result_t;

endpackage
`default_nettype wire

// ===== src/psc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_in_if
// Input item channel: valid/ready handshake with op and operand fields.
// ----------------------------------------------------------------------------
interface psc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] index;
  logic [7:0] value;
  logic [7:0] key_sense;
  logic [7:0] adc_sample;

  modport source (output valid, output op, output index, output value,
                  output key_sense, output adc_sample, input ready);
  modport sink   (input valid, input op, input index, input value,
                  input key_sense, input adc_sample, output ready);
endinterface
`default_nettype wire

// ===== src/psc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_out_if
// Result item channel: valid/ready handshake with display, key and ADC fields.
// ----------------------------------------------------------------------------
interface psc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seg_row_enable;
  logic [7:0]  seg_segments;
  logic [7:0]  chan_leds;
  logic [7:0]  master_leds;
  logic        master_update;
  logic [7:0]  key_row_drive;
  logic [7:0]  adc_mux_word;
  logic        adc_convert_pulse;
  logic [7:0]  key_code;
  logic [7:0]  key_stable_count;
  logic [15:0] adc_dirty_mask;
  logic [7:0]  read_value;

  modport source (output valid, output seg_row_enable, output seg_segments,
                  output chan_leds, output master_leds, output master_update,
                  output key_row_drive, output adc_mux_word, output adc_convert_pulse,
                  output key_code, output key_stable_count, output adc_dirty_mask,
                  output read_value, input ready);
  modport sink   (input valid, input seg_row_enable, input seg_segments,
                  input chan_leds, input master_leds, input master_update,
                  input key_row_drive, input adc_mux_word, input adc_convert_pulse,
                  input key_code, input key_stable_count, input adc_dirty_mask,
                  input read_value, output ready);
endinterface
`default_nettype wire

// ===== src/psc_disp_key.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_disp_key
// Digit and master LED stores, display multiplexing and keyboard scan with
// debounce counter.
// ----------------------------------------------------------------------------
module psc_disp_key #(
  parameter int MAX_DIGITS = psc_pkg::MAX_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire psc_pkg::psc_item_t  item,
  input  wire psc_pkg::psc_phase_t ph,
  input  wire psc_pkg::psc_cfg_t   cfg,
  output psc_pkg::psc_dk_res_t     res
);
  import psc_pkg::*;

  localparam int DIG_AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DIG_DEPTH = 1 << DIG_AW;

  logic [7:0] digit_r  [DIG_DEPTH];
  logic [7:0] master_r [MASTER_WORDS];
  logic [7:0] key_r, key_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  logic       is_tick;
  logic [3:0] ndig;
  logic [3:0] nrows;
  logic       row_on;
  logic       row_scan;
  logic [3:0] col;
  logic       found;
  logic [7:0] code;
  logic [7:0] bit_sel;
  logic       dig_wr;
  logic       mst_wr;

  assign is_tick = (item.op == OP_TICK);
  assign ndig    = (cfg.digits > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : cfg.digits;
  assign nrows   = (cfg.rows > 4'(KEY_ROWS)) ? 4'(KEY_ROWS) : cfg.rows;
  assign row_on  = ({1'b0, ph.count} < nrows);
  assign bit_sel = 8'd1 << ph.count;
  assign dig_wr  = fire && (item.op == OP_WR_DIGIT) && ({1'b0, item.index} < 5'(MAX_DIGITS));
  assign mst_wr  = fire && (item.op == OP_WR_MASTER) &&
                   ({1'b0, item.index} < 5'(MASTER_WORDS));
  // a held key locks the scan to its own row
  assign row_scan = row_on && ((key_r == NO_KEY) || (key_r[7:3] == {2'b00, ph.count}));

  always_comb begin
    col   = 4'd8;
    found = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (!found && !item.key_sense[c]) begin
        col   = 4'(c);
        found = 1'b1;
      end
    end
  end

  assign code = found ? {2'b00, ph.count, col[2:0]} : NO_KEY;

  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (is_tick && row_scan) begin
      if (code == key_r) begin
        if (cnt_r < cfg.debounce) begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end else begin
        cnt_nxt = 8'd0;
        key_nxt = code;
      end
    end
  end

  always_comb begin
    res = '0;
    res.key_row_drive    = 8'hff;
    res.key_code         = key_nxt;
    res.key_stable_count = cnt_nxt;
    if (is_tick) begin
      if ({1'b0, ph.count} < ndig) begin
        res.seg_row_enable = bit_sel;
        res.seg_segments   = digit_r[ph.count[DIG_AW-1:0]];
      end
      // slots 0, 1 and 3: each drives the channel and master LEDs from two master words
      case (ph.count)
        3'd0: begin
          res.chan_leds     = master_r[0];
          res.master_leds   = master_r[1];
          res.master_update = 1'b1;
        end
        3'd1: begin
          res.chan_leds     = master_r[2];
          res.master_leds   = master_r[3];
          res.master_update = 1'b1;
        end
        3'd3: begin
          res.chan_leds     = master_r[4];
          res.master_leds   = master_r[5];
          res.master_update = 1'b1;
        end
        default: begin
          res.master_update = 1'b0;
        end
      endcase
      if (row_on) begin
        res.key_row_drive = ~bit_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= NO_KEY;
      cnt_r <= 8'd0;
      for (int i = 0; i < DIG_DEPTH; i++) begin
        digit_r[i] <= 8'd0;
      end
      for (int i = 0; i < MASTER_WORDS; i++) begin
        master_r[i] <= 8'd0;
      end
    end else begin
      if (fire) begin
        key_r <= key_nxt;
        cnt_r <= cnt_nxt;
      end
      if (dig_wr) begin
        digit_r[item.index[DIG_AW-1:0]] <= item.value;
      end
      if (mst_wr) begin
        master_r[item.index[2:0]] <= item.value;
      end
    end
  end

  a_key_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (key_r == NO_KEY) || (key_r[7:6] == 2'b00))
    else $error("key code row out of range");

  a_key_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (key_nxt != key_r)) |=> (cnt_r == 8'd0))
    else $error("debounce count not cleared on key change");

  a_key_hold_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_tick) |=> ($stable(key_r) && $stable(cnt_r)))
    else $error("key state changed on a non-tick item");

endmodule
`default_nettype wire

// ===== src/psc_adc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_adc
// Analog multiplexer sequencing, per-channel sample store with deadband and
// dirty marks, sample read-back.
// ----------------------------------------------------------------------------
module psc_adc #(
  parameter int MAX_CHANNELS = psc_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire psc_pkg::psc_item_t  item,
  input  wire psc_pkg::psc_phase_t ph,
  input  wire psc_pkg::psc_cfg_t   cfg,
  output psc_pkg::psc_adc_res_t    res
);
  import psc_pkg::*;

  localparam int CH_AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_DEPTH = 1 << CH_AW;

  logic [7:0]         sample_r [CH_DEPTH];
  logic [DIRTY_W-1:0] dirty_r, dirty_nxt;
  logic [7:0]         mux_r, mux_nxt;

  logic [4:0] nch;
  logic       chan_on;
  logic [3:0] raddr;
  logic [7:0] rdata;
  logic [7:0] diff;
  logic       take;
  logic [4:0] nxt_full;
  logic [3:0] nxt;
  logic [7:0] word;
  logic       wr_en;
  logic       rd_ok;

  assign nch     = (cfg.channels > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : cfg.channels;
  assign chan_on = ({1'b0, ph.chan} < nch);
  assign rd_ok   = ({1'b0, item.index} < 5'(MAX_CHANNELS));
  // reads and tick updates never happen in the same item, so one read port
  assign raddr   = (item.op == OP_RD_SAMPLE) ? item.index : ph.chan;
  assign rdata   = sample_r[raddr[CH_AW-1:0]];
  assign diff    = rdata - item.adc_sample;
  assign take    = !((diff == 8'h00) || (diff == 8'h01) || (diff == 8'hff));

  assign nxt_full = {1'b0, ph.chan} + 5'd1;
  assign nxt      = (nxt_full >= nch) ? 4'd0 : nxt_full[3:0];

  always_comb begin
    word = {2'b00, nxt[0], nxt[1], nxt[2], 3'b111};
    if (nxt[3]) begin
      word[1] = 1'b0;
    end else begin
      word[2] = 1'b0;
    end
  end

  always_comb begin
    dirty_nxt = dirty_r;
    mux_nxt   = mux_r;
    wr_en     = 1'b0;
    res       = '0;
    case (item.op)
      OP_TICK: begin
        if (chan_on) begin
          if (!ph.count[0] && take) begin
            wr_en     = 1'b1;
            dirty_nxt = dirty_r | (DIRTY_W'(1) << ph.chan);
          end
          mux_nxt               = word;
          res.adc_convert_pulse = ph.count[0];
        end
      end
      OP_RD_SAMPLE: begin
        if (rd_ok) begin
          res.read_value = rdata;
          dirty_nxt      = dirty_r & ~(DIRTY_W'(1) << item.index);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    res.adc_mux_word   = mux_nxt;
    res.adc_dirty_mask = dirty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= '0;
      mux_r   <= 8'd0;
      for (int i = 0; i < CH_DEPTH; i++) begin
        sample_r[i] <= 8'd0;
      end
    end else if (fire) begin
      dirty_r <= dirty_nxt;
      mux_r   <= mux_nxt;
      if (wr_en) begin
        sample_r[ph.chan[CH_AW-1:0]] <= item.adc_sample;
      end
    end
  end

  a_read_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (item.op == OP_RD_SAMPLE) && rd_ok) |=> !dirty_r[$past(item.index)])
    else $error("sample read left its dirty bit set");

  a_sample_write_even: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && wr_en) |-> ((item.op == OP_TICK) && !ph.count[0] && chan_on))
    else $error("sample written outside an even tick");

  a_mux_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    (mux_r == 8'd0) || ((mux_r[7:6] == 2'b00) && mux_r[0] && (mux_r[1] != mux_r[2])))
    else $error("malformed mux word");

endmodule
`default_nettype wire

// ===== src/panel_scan_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// panel_scan_controller_core
// Keyboard / display / ADC-multiplexer scan controller with item handshake.
// ----------------------------------------------------------------------------
// path: item held in the input register, its result then in the result register
// throughput: one item per cycle; input register and result register each
//   hold one item, so while a result waits for its sink the input takes one
//   more item and then drops ready until the result is taken
// reset (rst_n low, synchronous): all stores, dirty bits, phase, debounce
//   state and mux word cleared, key code set to no key, registers to defaults
// ----------------------------------------------------------------------------
module panel_scan_controller_core #(
  parameter int MAX_DIGITS   = psc_pkg::MAX_DIGITS_DEF,
  parameter int MAX_CHANNELS = psc_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  psc_in_if.sink                               in_ch,
  psc_out_if.source                            out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import psc_pkg::*;

  psc_cfg_t    cfg_r;
  logic [4:0]  phase_r, phase_nxt;
  logic [4:0]  phase_inc;
  logic        in_vld_r;
  psc_item_t   in_r;
  logic        out_vld_r;
  psc_result_t out_r;

  logic         move;
  logic         accept;
  psc_phase_t   ph;
  psc_dk_res_t  dk_res;
  psc_adc_res_t adc_res;

  // item leaves the input register when the result register is free or being taken
  assign move   = in_vld_r && (!out_vld_r || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_vld_r || move;

  assign phase_inc = phase_r + 5'd1;
  assign ph.count  = phase_inc[2:0];
  assign ph.chan   = phase_inc[4:1];
  assign phase_nxt = (in_r.op == OP_TICK) ? phase_inc : phase_r;

  psc_disp_key #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_disp_key (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (move),
    .item  (in_r),
    .ph    (ph),
    .cfg   (cfg_r),
    .res   (dk_res)
  );

  psc_adc #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_adc (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (move),
    .item  (in_r),
    .ph    (ph),
    .cfg   (cfg_r),
    .res   (adc_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.digits   <= 4'd8;
      cfg_r.rows     <= 4'd8;
      cfg_r.channels <= 5'd16;
      cfg_r.debounce <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIGITS:   cfg_r.digits   <= cfg_wdata[3:0];
        CFG_ROWS:     cfg_r.rows     <= cfg_wdata[3:0];
        CFG_CHANNELS: cfg_r.channels <= cfg_wdata[4:0];
        CFG_DEBOUNCE: cfg_r.debounce <= cfg_wdata;
        default:      cfg_r.debounce <= cfg_r.debounce;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 5'd0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (move) begin
        in_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
        phase_r   <= phase_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r.op         <= psc_op_t'(in_ch.op);
      in_r.index      <= in_ch.index;
      in_r.value      <= in_ch.value;
      in_r.key_sense  <= in_ch.key_sense;
      in_r.adc_sample <= in_ch.adc_sample;
    end
    if (move) begin
      out_r.dk  <= dk_res;
      out_r.adc <= adc_res;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.seg_row_enable    = out_r.dk.seg_row_enable;
  assign out_ch.seg_segments      = out_r.dk.seg_segments;
  assign out_ch.chan_leds         = out_r.dk.chan_leds;
  assign out_ch.master_leds       = out_r.dk.master_leds;
  assign out_ch.master_update     = out_r.dk.master_update;
  assign out_ch.key_row_drive     = out_r.dk.key_row_drive;
  assign out_ch.adc_mux_word      = out_r.adc.adc_mux_word;
  assign out_ch.adc_convert_pulse = out_r.adc.adc_convert_pulse;
  assign out_ch.key_code          = out_r.dk.key_code;
  assign out_ch.key_stable_count  = out_r.dk.key_stable_count;
  assign out_ch.adc_dirty_mask    = out_r.adc.adc_dirty_mask;
  assign out_ch.read_value        = out_r.adc.read_value;

  a_move_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_vld_r)
    else $error("moved item did not reach the result register");

  a_phase_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (move && (in_r.op == OP_TICK)) |=> (phase_r == 5'($past(phase_r) + 5'd1)))
    else $error("phase did not advance on a tick");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(move && (in_r.op == OP_TICK)) |=> $stable(phase_r))
    else $error("phase changed without a tick");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the panel scan controller core: a directed opening
// (store writes, out-of-range indexes, key and sample corner cases), then
// random ticks with held keys and jittering samples under several register
// settings, checked field by field against a bench predictor or reset values.
// ----------------------------------------------------------------------------
module tb;
  import psc_pkg::*;

  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 240;
  localparam int HOLD_CYCLES = 300;
  localparam int OPENING     = 25;

  // non-tick op straight after reset: every field at its reset value
  localparam psc_result_t AT_RESET = '{
    dk: '{seg_row_enable: 8'h00, seg_segments: 8'h00, chan_leds: 8'h00,
          master_leds: 8'h00, master_update: 1'b0, key_row_drive: 8'hff,
          key_code: NO_KEY, key_stable_count: 8'h00},
    adc: '0};

  typedef struct packed {
    psc_item_t   item;
    logic        typed;
    psc_result_t want;
  } scan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  psc_in_if  in_ch ();
  psc_out_if out_ch ();

  panel_scan_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the block state
  psc_cfg_t   cfg_now = '{digits: 4'd8, rows: 4'd8, channels: 5'd16, debounce: 8'd8};
  logic [4:0]  phase_now = '0;
  logic [7:0]  digit_mem [MAX_DIGITS_DEF] = '{default: 8'h00};
  logic [7:0]  master_mem [MASTER_WORDS] = '{default: 8'h00};
  logic [7:0]  sample_mem [MAX_CHANNELS_DEF] = '{default: 8'h00};
  logic [15:0] dirty_now = '0;
  logic [7:0]  key_now = NO_KEY;
  logic [7:0]  key_cnt = '0;
  logic [7:0]  mux_now = '0;

  psc_result_t scan_results_due [$];

  // stimulus shaping state
  int         press_row = 8;
  int         press_col = 0;
  int         press_left = 0;
  logic [7:0] adc_level [MAX_CHANNELS_DEF] = '{default: 8'h00};

  bit hold_request = 1'b0;
  bit stall_on = 1'b1;
  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int ticks_sent = 0;

  task automatic predict_scan(input psc_item_t it, output psc_result_t r);
    logic [2:0] cnt;
    logic [3:0] ch;
    logic [7:0] onehot, code, diff, mw;
    int ndig, nrow, nch, nxt, slot, col;
    r = '0;
    r.dk.key_row_drive = 8'hff;
    case (it.op)
      OP_TICK: begin
        phase_now = phase_now + 5'd1;
        cnt = phase_now[2:0];
        ch = phase_now[4:1];
        onehot = 8'd1 << cnt;
        ndig = (cfg_now.digits > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : cfg_now.digits;
        if (cnt < ndig) begin
          r.dk.seg_row_enable = onehot;
          r.dk.seg_segments = digit_mem[cnt];
        end
        // led slots 0, 1 and 3
        case (cnt)
          3'd0: slot = 0;
          3'd1: slot = 2;
          3'd3: slot = 4;
          default: slot = -1;
        endcase
        if (slot >= 0) begin
          r.dk.chan_leds = master_mem[3'(slot)];
          r.dk.master_leds = master_mem[3'(slot + 1)];
          r.dk.master_update = 1'b1;
        end
        nrow = (cfg_now.rows > KEY_ROWS) ? KEY_ROWS : cfg_now.rows;
        if (cnt < nrow) begin
          r.dk.key_row_drive = ~onehot;
          if (key_now == NO_KEY || key_now[7:3] == {2'b00, cnt}) begin
            col = 8;
            for (int c = 7; c >= 0; c--) if (!it.key_sense[c]) col = c;
            code = (col == 8) ? NO_KEY : {2'b00, cnt, 3'(col)};
            if (code == key_now) begin
              if (key_cnt < cfg_now.debounce) key_cnt = key_cnt + 8'd1;
            end else begin
              key_cnt = '0;
              key_now = code;
            end
          end
        end
        nch = (cfg_now.channels > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : cfg_now.channels;
        if (ch < nch) begin
          if (!cnt[0]) begin
            diff = sample_mem[ch] - it.adc_sample;
            // deadband of plus or minus one
            if (diff != 8'h00 && diff != 8'h01 && diff != 8'hff) begin
              sample_mem[ch] = it.adc_sample;
              dirty_now[ch] = 1'b1;
            end
          end
          nxt = (ch + 1 >= nch) ? 0 : ch + 1;
          mw = {2'b00, nxt[0], nxt[1], nxt[2], 3'b111};
          if (nxt[3]) mw[1] = 1'b0;
          else mw[2] = 1'b0;
          mux_now = mw;
          r.adc.adc_convert_pulse = cnt[0];
        end
      end
      OP_WR_DIGIT: begin
        if (it.index < MAX_DIGITS_DEF) digit_mem[it.index[2:0]] = it.value;
      end
      OP_WR_MASTER: begin
        if (it.index < MASTER_WORDS) master_mem[it.index[2:0]] = it.value;
      end
      default: begin
        r.adc.read_value = sample_mem[it.index];
        dirty_now[it.index] = 1'b0;
      end
    endcase
    r.adc.adc_mux_word = mux_now;
    r.adc.adc_dirty_mask = dirty_now;
    r.dk.key_code = key_now;
    r.dk.key_stable_count = key_cnt;
  endtask

  function automatic scan_row_t dr(psc_op_t op, logic [3:0] idx, logic [7:0] val,
                                   logic [7:0] sense, logic [7:0] smp,
                                   logic typed = 1'b0);
    scan_row_t row;
    row.item = '{op: op, index: idx, value: val, key_sense: sense, adc_sample: smp};
    row.typed = typed;
    row.want = AT_RESET;
    return row;
  endfunction

  // mostly ticks with a held key and slowly moving samples, some store traffic
  function automatic psc_item_t pick_item();
    psc_item_t it;
    logic [2:0] cnt;
    logic [3:0] ch;
    int r;
    it.op = OP_TICK;
    it.index = 4'($urandom_range(0, 15));
    it.value = 8'($urandom);
    it.key_sense = 8'hff;
    it.adc_sample = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 7) it.op = OP_WR_DIGIT;
    else if (r < 12) it.op = OP_WR_MASTER;
    else if (r < 22) it.op = OP_RD_SAMPLE;
    else if (r >= 93) begin
      it.key_sense = 8'($urandom);
      return it;
    end
    cnt = phase_now[2:0] + 3'd1;
    ch = 4'((phase_now + 5'd1) >> 1);
    if (press_left == 0) begin
      press_row = $urandom_range(0, 10);
      press_col = $urandom_range(0, 7);
      press_left = $urandom_range(4, 60);
    end
    if (it.op == OP_TICK) press_left--;
    if (press_row == cnt) begin
      it.key_sense = 8'($urandom) | ((8'd1 << press_col) - 8'd1);
      it.key_sense[press_col] = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      it.key_sense = 8'($urandom);
    end
    if ($urandom_range(0, 15) == 0) adc_level[ch] = 8'($urandom);
    it.adc_sample = adc_level[ch] + 8'($urandom_range(0, 2)) - 8'd1;
    return it;
  endfunction

  task automatic send_item(input psc_item_t it, input bit gaps,
                           input logic typed = 1'b0, input psc_result_t want = '0);
    psc_result_t r;
    if (gaps && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.index <= it.index;
    in_ch.value <= it.value;
    in_ch.key_sense <= it.key_sense;
    in_ch.adc_sample <= it.adc_sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_scan(it, r);
    scan_results_due.push_back(typed ? want : r);
    items_sent++;
    if (it.op == OP_TICK) ticks_sent++;
  endtask

  task automatic apply_setting(input psc_cfg_t s);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIGITS;
    cfg_wdata <= {4'($urandom), s.digits};
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= {4'($urandom), s.rows};
    @(posedge clk);
    cfg_index <= CFG_CHANNELS;
    cfg_wdata <= {3'($urandom), s.channels};
    @(posedge clk);
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= s.debounce;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_now = s;
  endtask

  task automatic drain();
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  // result sink: random stall bursts, or one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    psc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (scan_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result item with nothing expected", $time);
      end else begin
        want = scan_results_due.pop_front();
        results_checked++;
        check_field("seg_row_enable", want.dk.seg_row_enable, out_ch.seg_row_enable);
        check_field("seg_segments", want.dk.seg_segments, out_ch.seg_segments);
        check_field("chan_leds", want.dk.chan_leds, out_ch.chan_leds);
        check_field("master_leds", want.dk.master_leds, out_ch.master_leds);
        check_field("master_update", want.dk.master_update, out_ch.master_update);
        check_field("key_row_drive", want.dk.key_row_drive, out_ch.key_row_drive);
        check_field("adc_mux_word", want.adc.adc_mux_word, out_ch.adc_mux_word);
        check_field("adc_convert_pulse", want.adc.adc_convert_pulse,
                    out_ch.adc_convert_pulse);
        check_field("key_code", want.dk.key_code, out_ch.key_code);
        check_field("key_stable_count", want.dk.key_stable_count, out_ch.key_stable_count);
        check_field("adc_dirty_mask", want.adc.adc_dirty_mask, out_ch.adc_dirty_mask);
        check_field("read_value", want.adc.read_value, out_ch.read_value);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    scan_row_t opening [OPENING];
    psc_cfg_t settings [PHASES];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_TICK;
    in_ch.index <= '0;
    in_ch.value <= '0;
    in_ch.key_sense <= '0;
    in_ch.adc_sample <= '0;

    opening = '{
      dr(OP_RD_SAMPLE, 4'd0, 8'h00, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_DIGIT, 4'd15, 8'hff, 8'hff, 8'hff, 1'b1),   // out of range, dropped
      dr(OP_WR_MASTER, 4'd6, 8'hff, 8'h00, 8'h00, 1'b1),   // out of range, dropped
      dr(OP_WR_DIGIT, 4'd0, 8'hff, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_DIGIT, 4'd1, 8'h81, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_DIGIT, 4'd7, 8'h7e, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_MASTER, 4'd0, 8'h01, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_MASTER, 4'd1, 8'hfe, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_MASTER, 4'd2, 8'haa, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_MASTER, 4'd3, 8'h55, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_MASTER, 4'd4, 8'hf0, 8'h00, 8'h00, 1'b1),
      dr(OP_WR_MASTER, 4'd5, 8'h0f, 8'h00, 8'h00, 1'b1),
      dr(OP_TICK, 4'd0, 8'h00, 8'hff, 8'h00),
      dr(OP_TICK, 4'd0, 8'h00, 8'hfe, 8'h80),    // key on row 2, big sample jump
      dr(OP_TICK, 4'd0, 8'h00, 8'h7f, 8'h01),    // held key elsewhere, row ignored
      dr(OP_TICK, 4'd0, 8'h00, 8'h00, 8'h01),    // sample inside deadband
      dr(OP_TICK, 4'd0, 8'h00, 8'h00, 8'h02),
      dr(OP_TICK, 4'd0, 8'h00, 8'h7f, 8'hff),    // deadband the other way
      dr(OP_TICK, 4'd0, 8'h00, 8'hff, 8'hff),
      dr(OP_TICK, 4'd0, 8'h00, 8'hff, 8'hfe),    // just outside deadband
      dr(OP_TICK, 4'd0, 8'h00, 8'hff, 8'h00),
      dr(OP_TICK, 4'd0, 8'h00, 8'hfe, 8'h00),    // same key again, count up
      dr(OP_TICK, 4'd0, 8'h00, 8'h01, 8'h00),
      dr(OP_RD_SAMPLE, 4'd1, 8'h00, 8'h00, 8'h00),
      dr(OP_RD_SAMPLE, 4'd15, 8'hff, 8'hff, 8'hff)
    };
    settings[0] = '{digits: 4'd8, rows: 4'd8, channels: 5'd16, debounce: 8'd8};
    settings[1] = '{digits: 4'd0, rows: 4'd0, channels: 5'd0, debounce: 8'd0};
    settings[2] = '{digits: 4'd15, rows: 4'd15, channels: 5'd31, debounce: 8'd255};
    settings[3] = '{digits: 4'd3, rows: 4'd2, channels: 5'd5, debounce: 8'd2};
    settings[4] = '{digits: 4'd1, rows: 4'd1, channels: 5'd1, debounce: 8'd1};
    settings[5] = '{digits: 4'($urandom), rows: 4'($urandom), channels: 5'($urandom),
                    debounce: 8'($urandom)};
    settings[6] = '{digits: 4'd8, rows: 4'd8, channels: 5'd16, debounce: 8'd0};
    settings[7] = '{digits: 4'($urandom_range(0, 9)), rows: 4'($urandom_range(0, 9)),
                    channels: 5'($urandom_range(1, 17)), debounce: 8'($urandom_range(0, 6))};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i])
      send_item(opening[i].item, 1'b1, opening[i].typed, opening[i].want);
    in_ch.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      apply_setting(settings[p]);
      // no idling on either side in the closing phase
      if (p == PHASES - 1) stall_on = 1'b0;
      for (int n = 0; n < PER_PHASE; n++) begin
        // sink holds off while items keep coming, so the input backs up
        if (p == 0 && n == 100) hold_request = 1'b1;
        send_item(pick_item(), p != PHASES - 1);
      end
      in_ch.valid <= 1'b0;
    end
    drain();
    repeat (8) @(posedge clk);

    $display("%0d items (%0d ticks) sent, %0d results checked, %0d mismatches",
             items_sent, ticks_sent, results_checked, mismatches);
    $display("covered %0d register settings incl. zero and all-ones extremes", PHASES);
    if (mismatches == 0 && scan_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
